FILE: rtl/mvne_pkg.sv
// Shared types, constants and field widths of the vertex normal engine.
package mvne_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int VERT_W       = 12;
  localparam int COORD_W      = 16;
  localparam int POS_W        = 3 * COORD_W;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int SUM_W        = 2 * COORD_W + 5;
  localparam int SUMS_W       = 3 * SUM_W;
  localparam int NORM_W       = 16;
  localparam int ACT_W        = 2;
  localparam int QDEPTH       = 2;
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 64;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TRI   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic signed [NORM_W-1:0] UNIT_Q14 = 16'sd16384;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_TRI   = 2'd1,
    K_READ  = 2'd2,
    K_UP    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic [VERT_W-1:0]          a;
    logic [VERT_W-1:0]          b;
    logic [VERT_W-1:0]          c;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
  } cmd_t;

endpackage

FILE: rtl/mvne_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mvne_front.sv
// Input acceptance, command classification and command queue.
module mvne_front #(
  parameter int MAX_VERTICES = mvne_pkg::MAX_VERTICES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mvne_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic [mvne_pkg::ACT_W-1:0]          s_axis_tuser_i,
  input  logic                                init_done_i,
  input  logic                                pop_i,
  output logic                                cmd_valid_o,
  output mvne_pkg::cmd_t                      cmd_o
);

  localparam int PTR_W = $clog2(mvne_pkg::QDEPTH);

  mvne_pkg::cmd_t            fifo_q [mvne_pkg::QDEPTH];
  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]            count_q, count_d;
  mvne_pkg::cmd_t            cmd_in;
  logic                      keep, accept, push, pop;
  logic                      a_ok, b_ok, c_ok;

  assign a_ok = 32'(s_axis_tdata_i[11:0]) < MAX_VERTICES;
  assign b_ok = 32'(s_axis_tdata_i[23:12]) < MAX_VERTICES;
  assign c_ok = 32'(s_axis_tdata_i[35:24]) < MAX_VERTICES;

  always_comb begin
    cmd_in.a    = s_axis_tdata_i[11:0];
    cmd_in.b    = s_axis_tdata_i[23:12];
    cmd_in.c    = s_axis_tdata_i[35:24];
    cmd_in.px   = s_axis_tdata_i[51:36];
    cmd_in.py   = s_axis_tdata_i[67:52];
    cmd_in.pz   = s_axis_tdata_i[83:68];
    keep        = 1'b0;
    cmd_in.kind = mvne_pkg::K_UP;
    case (s_axis_tuser_i)
      mvne_pkg::ACT_WRITE: begin
        keep        = a_ok;
        cmd_in.kind = mvne_pkg::K_WRITE;
      end
      mvne_pkg::ACT_TRI: begin
        keep        = a_ok && b_ok && c_ok;
        cmd_in.kind = mvne_pkg::K_TRI;
      end
      mvne_pkg::ACT_READ: begin
        keep        = 1'b1;
        cmd_in.kind = a_ok ? mvne_pkg::K_READ : mvne_pkg::K_UP;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_axis_tready_o = init_done_i && (count_q != (PTR_W+1)'(mvne_pkg::QDEPTH));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = accept && keep;
  assign cmd_valid_o     = count_q != '0;
  assign pop             = pop_i && cmd_valid_o;
  assign cmd_o           = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/mvne_norm.sv
// Iterative normaliser: scaling, sum of squares, square root and division.
module mvne_norm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mvne_pkg::SUMS_W-1:0]         sums_i,
  output logic                                done_o,
  output logic signed [mvne_pkg::NORM_W-1:0]  nx_o,
  output logic signed [mvne_pkg::NORM_W-1:0]  ny_o,
  output logic signed [mvne_pkg::NORM_W-1:0]  nz_o
);

  localparam int SW  = mvne_pkg::SUM_W;
  localparam int MW  = 30;
  localparam int SQW = 2 * MW;
  localparam int VW  = SQW + 2;
  localparam int RW  = MW + 1;
  localparam int DW  = MW + 15;
  localparam int QW  = 15;

  typedef enum logic [7:0] {
    N_IDLE  = 8'b00000001,
    N_SHIFT = 8'b00000010,
    N_SQ    = 8'b00000100,
    N_SUM   = 8'b00001000,
    N_SQRT  = 8'b00010000,
    N_DINIT = 8'b00100000,
    N_DIV   = 8'b01000000,
    N_DONE  = 8'b10000000
  } nstate_e;

  nstate_e                state_q, state_d;
  logic [SW-1:0]          m_q [3];
  logic [SW-1:0]          m_d [3];
  logic [2:0]             sgn_q, sgn_d;
  logic [SQW-1:0]         sq_q [3];
  logic [VW-1:0]          v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [VW:0]            trial;
  logic [RW-1:0]          r_q, r_d;
  logic [DW-1:0]          rem_q, rem_d, dv_q, dv_d;
  logic [QW-1:0]          quo_q, quo_d;
  logic [4:0]             cnt_q, cnt_d;
  logic [1:0]             j_q, j_d;
  logic signed [mvne_pkg::NORM_W-1:0] n_q [3];
  logic signed [mvne_pkg::NORM_W-1:0] n_d [3];
  logic [SW-1:0]          mmax;
  logic signed [SW-1:0]   s_in [3];

  always_comb begin
    s_in[0] = sums_i[SW-1:0];
    s_in[1] = sums_i[2*SW-1:SW];
    s_in[2] = sums_i[3*SW-1:2*SW];
    mmax = m_q[0];
    if (m_q[1] > mmax) mmax = m_q[1];
    if (m_q[2] > mmax) mmax = m_q[2];
    trial = (VW+1)'(res_q) + (VW+1)'(bit_q);
  end

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    sgn_d   = sgn_q;
    v_d     = v_q;
    res_d   = res_q;
    bit_d   = bit_q;
    r_d     = r_q;
    rem_d   = rem_q;
    dv_d    = dv_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    n_d     = n_q;
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            sgn_d[i] = s_in[i][SW-1];
            m_d[i]   = s_in[i][SW-1] ? SW'(-s_in[i]) : SW'(s_in[i]);
          end
          if (s_in[0] == '0 && s_in[1] == '0 && s_in[2] == '0) begin
            n_d[0]  = '0;
            n_d[1]  = mvne_pkg::UNIT_Q14;
            n_d[2]  = '0;
            state_d = N_DONE;
          end else begin
            state_d = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        if (mmax[SW-1:MW] != '0) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (!mmax[MW-1]) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        state_d = N_SUM;
      end
      N_SUM: begin
        v_d     = VW'(sq_q[0]) + VW'(sq_q[1]) + VW'(sq_q[2]);
        res_d   = '0;
        bit_d   = VW'(1) << (VW - 2);
        cnt_d   = '0;
        state_d = N_SQRT;
      end
      N_SQRT: begin
        if ((VW+1)'(v_q) >= trial) begin
          v_d   = v_q - VW'(trial);
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(VW/2 - 1)) begin
          r_d     = RW'(res_d);
          j_d     = '0;
          state_d = N_DINIT;
        end
      end
      N_DINIT: begin
        rem_d   = {m_q[j_q][MW-1:0], 14'b0} + DW'(r_q >> 1);
        dv_d    = {r_q, 14'b0};
        quo_d   = '0;
        cnt_d   = '0;
        state_d = N_DIV;
      end
      N_DIV: begin
        if (rem_q >= dv_q) begin
          rem_d = rem_q - dv_q;
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        dv_d  = dv_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(QW - 1)) begin
          n_d[j_q] = sgn_q[j_q] ? -$signed(mvne_pkg::NORM_W'(quo_d))
                                :  $signed(mvne_pkg::NORM_W'(quo_d));
          if (j_q == 2'd2) begin
            state_d = N_DONE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = N_DINIT;
          end
        end
      end
      N_DONE: begin
        state_d = N_IDLE;
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    sgn_q <= sgn_d;
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
    r_q   <= r_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    j_q   <= j_d;
    n_q   <= n_d;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= m_q[i][MW-1:0] * m_q[i][MW-1:0];
    end
  end

  assign done_o = state_q == N_DONE;
  assign nx_o   = n_q[0];
  assign ny_o   = n_q[1];
  assign nz_o   = n_q[2];

endmodule

FILE: rtl/mvne_back.sv
// Command sequencer: position and sum stores, cross product, accumulation, output register.
module mvne_back #(
  parameter int MAX_VERTICES = mvne_pkg::MAX_VERTICES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  mvne_pkg::cmd_t                      cmd_i,
  output logic                                pop_o,
  output logic                                init_done_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [mvne_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = mvne_pkg::COORD_W;
  localparam int EW = mvne_pkg::EDGE_W;
  localparam int PW = mvne_pkg::PROD_W;
  localparam int XW = mvne_pkg::CROSS_W;
  localparam int SW = mvne_pkg::SUM_W;
  localparam int NW = mvne_pkg::NORM_W;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_PRD   = 11'b00000000100,
    S_EDGE  = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_SUB   = 11'b00000100000,
    S_ARD   = 11'b00001000000,
    S_AWR   = 11'b00010000000,
    S_RWAIT = 11'b00100000000,
    S_NWAIT = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } bstate_e;

  bstate_e                  state_q, state_d;
  mvne_pkg::cmd_t           cmd_q, cmd_d;
  logic [AW-1:0]            clr_addr_q, clr_addr_d;
  logic [1:0]               cnt_q, cnt_d;
  logic [mvne_pkg::POS_W-1:0] pa_q, pb_q, pa_d, pb_d, pc_q, pc_d;
  logic signed [EW-1:0]     e1_q [3];
  logic signed [EW-1:0]     e2_q [3];
  logic signed [PW-1:0]     pr_q [6];
  logic signed [XW-1:0]     cr_q [3];
  logic signed [NW-1:0]     res_q [3];
  logic signed [NW-1:0]     res_d [3];

  logic                     pos_we, pos_re, sum_we, sum_re;
  logic [AW-1:0]            pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [mvne_pkg::POS_W-1:0] pos_rdata;
  logic [mvne_pkg::SUMS_W-1:0] sum_wdata, sum_rdata;
  logic                     norm_start, norm_done;
  logic signed [NW-1:0]     nx, ny, nz;
  logic [AW-1:0]            corner;
  logic signed [SW:0]       acc [3];
  logic [SW-1:0]            accs [3];

  logic                     out_valid_q, out_valid_d;
  logic [mvne_pkg::VERT_W-1:0] out_vertex_q, out_vertex_d;
  logic signed [NW-1:0]     out_n_q [3];
  logic signed [NW-1:0]     out_n_d [3];
  logic                     out_load;

  mvne_ram #(.WIDTH(mvne_pkg::POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i ({cmd_i.pz, cmd_i.py, cmd_i.px}),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  mvne_ram #(.WIDTH(mvne_pkg::SUMS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  mvne_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .sums_i  (sum_rdata),
    .done_o  (norm_done),
    .nx_o    (nx),
    .ny_o    (ny),
    .nz_o    (nz)
  );

  always_comb begin
    case (cnt_q)
      2'd0:    corner = AW'(cmd_q.a);
      2'd1:    corner = AW'(cmd_q.b);
      default: corner = AW'(cmd_q.c);
    endcase
    for (int i = 0; i < 3; i++) begin
      acc[i] = (SW+1)'($signed(sum_rdata[i*SW +: SW])) + (SW+1)'(cr_q[i]);
      if (acc[i][SW] != acc[i][SW-1]) begin
        accs[i] = acc[i][SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        accs[i] = acc[i][SW-1:0];
      end
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    clr_addr_d = clr_addr_q;
    cnt_d      = cnt_q;
    pa_d       = pa_q;
    pb_d       = pb_q;
    pc_d       = pc_q;
    res_d      = res_q;
    pop_o      = 1'b0;
    pos_we     = 1'b0;
    pos_waddr  = AW'(cmd_i.a);
    pos_re     = 1'b0;
    pos_raddr  = AW'(cmd_q.a);
    sum_we     = 1'b0;
    sum_waddr  = corner;
    sum_wdata  = {accs[2], accs[1], accs[0]};
    sum_re     = 1'b0;
    sum_raddr  = corner;
    norm_start = 1'b0;
    case (state_q)
      S_CLEAR: begin
        sum_we     = 1'b1;
        sum_waddr  = clr_addr_q;
        sum_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(MAX_VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          cnt_d = '0;
          case (cmd_i.kind)
            mvne_pkg::K_WRITE: begin
              pos_we = 1'b1;
            end
            mvne_pkg::K_TRI: begin
              state_d = S_PRD;
            end
            mvne_pkg::K_READ: begin
              sum_re    = 1'b1;
              sum_raddr = AW'(cmd_i.a);
              state_d   = S_RWAIT;
            end
            default: begin
              res_d[0] = '0;
              res_d[1] = mvne_pkg::UNIT_Q14;
              res_d[2] = '0;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_PRD: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q)
          2'd0: begin
            pos_re    = 1'b1;
            pos_raddr = AW'(cmd_q.a);
          end
          2'd1: begin
            pos_re    = 1'b1;
            pos_raddr = AW'(cmd_q.b);
            pa_d      = pos_rdata;
          end
          2'd2: begin
            pos_re    = 1'b1;
            pos_raddr = AW'(cmd_q.c);
            pb_d      = pos_rdata;
          end
          default: begin
            pc_d    = pos_rdata;
            state_d = S_EDGE;
          end
        endcase
      end
      S_EDGE: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_SUB;
      end
      S_SUB: begin
        cnt_d   = '0;
        state_d = S_ARD;
      end
      S_ARD: begin
        sum_re  = 1'b1;
        state_d = S_AWR;
      end
      S_AWR: begin
        sum_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        state_d = (cnt_q == 2'd2) ? S_IDLE : S_ARD;
      end
      S_RWAIT: begin
        norm_start = 1'b1;
        sum_we     = 1'b1;
        sum_waddr  = AW'(cmd_q.a);
        sum_wdata  = '0;
        state_d    = S_NWAIT;
      end
      S_NWAIT: begin
        if (norm_done) begin
          res_d[0] = nx;
          res_d[1] = ny;
          res_d[2] = nz;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_vertex_d = out_vertex_q;
    out_n_d      = out_n_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_vertex_d = cmd_q.a;
      out_n_d      = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    cnt_q        <= cnt_d;
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    pc_q         <= pc_d;
    res_q        <= res_d;
    out_vertex_q <= out_vertex_d;
    out_n_q      <= out_n_d;
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= EW'($signed(pb_q[i*CW +: CW])) - EW'($signed(pa_q[i*CW +: CW]));
      e2_q[i] <= EW'($signed(pc_q[i*CW +: CW])) - EW'($signed(pa_q[i*CW +: CW]));
    end
    pr_q[0] <= e1_q[1] * e2_q[2];
    pr_q[1] <= e1_q[2] * e2_q[1];
    pr_q[2] <= e1_q[2] * e2_q[0];
    pr_q[3] <= e1_q[0] * e2_q[2];
    pr_q[4] <= e1_q[0] * e2_q[1];
    pr_q[5] <= e1_q[1] * e2_q[0];
    cr_q[0] <= XW'(pr_q[0]) - XW'(pr_q[1]);
    cr_q[1] <= XW'(pr_q[2]) - XW'(pr_q[3]);
    cr_q[2] <= XW'(pr_q[4]) - XW'(pr_q[5]);
  end

  assign init_done_o     = state_q != S_CLEAR;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_n_q[2], out_n_q[1], out_n_q[0], out_vertex_q};

  a_norm_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> state_q == S_NWAIT)
    else $error("normaliser finished outside its wait state");

  a_norm_start_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_start |=> state_q == S_NWAIT)
    else $error("normaliser started without waiting for it");

  a_clear_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && (clr_addr_q != AW'(MAX_VERTICES - 1)) |=> state_q == S_CLEAR)
    else $error("clearing pass left early");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o && !sum_re)
    else $error("command taken during clearing pass");

endmodule

FILE: rtl/mesh_vertex_normal_engine_unit.sv
// Top level of the vertex normal engine: command front end and sequencer.
// Position write: done in the sequencer once the queue head reaches it.
// Triangle: three position reads, cross product, three sum updates.
// Normal read: runs the scaling shift, the 31-step square root and three 15-step divisions
// in the shared normaliser, all skipped for a zero sum; results leave through a register.
// After reset the sum store is cleared, all MAX_VERTICES entries, before the first
// transaction.
module mesh_vertex_normal_engine_unit #(
  parameter int MAX_VERTICES = mvne_pkg::MAX_VERTICES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // vertex_a, vertex_b, vertex_c, pos_x, pos_height, pos_z, zero fill
  input  logic [mvne_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // action
  input  logic [mvne_pkg::ACT_W-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_vertex, normal_x, normal_y, normal_z, zero fill
  output logic [mvne_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  logic           init_done, pop, cmd_valid;
  mvne_pkg::cmd_t cmd;

  mvne_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .init_done_i     (init_done),
    .pop_i           (pop),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  mvne_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .pop_o           (pop),
    .init_done_o     (init_done),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the vertex normal engine: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;

  localparam int VW = mvne_pkg::VERT_W;
  localparam int CW = mvne_pkg::COORD_W;
  localparam int NW = mvne_pkg::NORM_W;
  localparam int AW = mvne_pkg::ACT_W;
  localparam int NV = mvne_pkg::MAX_VERTICES;
  localparam logic [AW-1:0] ACT_IGNORED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 630;
  localparam int ROW_MAX = 64;
  localparam int PEND_DEPTH = 1024;
  localparam longint SUM_HI = (64'sd1 <<< (mvne_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [VW-1:0] vert;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] nz;
  } normal_t;

  typedef struct {
    logic [AW-1:0]   act;
    logic [VW-1:0]   a, b, c;
    logic [CW-1:0]   px, py, pz;
    bit              typed;
    logic [NW-1:0]   ex, ey, ez;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mvne_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [AW-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mvne_pkg::OUT_DATA_W-1:0] m_tdata;

  logic signed [CW-1:0] pos_x [NV];
  logic signed [CW-1:0] pos_y [NV];
  logic signed [CW-1:0] pos_z [NV];
  longint sum_x [NV];
  longint sum_y [NV];
  longint sum_z [NV];
  bit written [NV];
  logic [VW-1:0] written_list [NV];
  int written_cnt = 0;

  normal_t pend_normals [PEND_DEPTH];
  int pend_wr = 0;
  int pend_rd = 0;
  dir_row_t rows [ROW_MAX];
  int n_rows = 0;
  int errors = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  mesh_vertex_normal_engine_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic longint sat_sum(longint acc, longint add);
    longint r;
    r = acc + add;
    if (r > SUM_HI) return SUM_HI;
    if (r < SUM_LO) return SUM_LO;
    return r;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [NW-1:0] scale_comp(longint s, logic [63:0] m, logic [63:0] r);
    logic [63:0] q;
    q = (m * 64'd16384 + r / 2) / r;
    if (s < 0) q = 64'd0 - q;
    return q[NW-1:0];
  endfunction

  function automatic normal_t unit_normal(logic [VW-1:0] v, longint sx, longint sy,
                                          longint sz);
    normal_t n;
    logic [63:0] mx, my, mz, mm, r;
    n.vert = v;
    n.nx = '0;
    n.ny = mvne_pkg::UNIT_Q14;
    n.nz = '0;
    mx = (sx < 0) ? -sx : sx;
    my = (sy < 0) ? -sy : sy;
    mz = (sz < 0) ? -sz : sz;
    mm = mx;
    if (my > mm) mm = my;
    if (mz > mm) mm = mz;
    if (mm != 0) begin
      while (mm >= (64'd1 << 30)) begin
        mm >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
      end
      while (mm < (64'd1 << 29)) begin
        mm <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
      end
      r = int_sqrt(mx * mx + my * my + mz * mz);
      n.nx = scale_comp(sx, mx, r);
      n.ny = scale_comp(sy, my, r);
      n.nz = scale_comp(sz, mz, r);
    end
    return n;
  endfunction

  // Advance the engine model by one accepted transaction; return 1 with the normal on a read.
  function automatic bit model_step(logic [AW-1:0] act, logic [VW-1:0] a,
                                    logic [VW-1:0] b, logic [VW-1:0] c,
                                    logic [CW-1:0] px, logic [CW-1:0] py,
                                    logic [CW-1:0] pz, output normal_t n);
    longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
    int corner [3];
    n = '0;
    case (act)
      mvne_pkg::ACT_WRITE: begin
        pos_x[a] = px;
        pos_y[a] = py;
        pos_z[a] = pz;
        if (!written[a]) begin
          written[a] = 1'b1;
          written_list[written_cnt] = a;
          written_cnt++;
        end
        return 1'b0;
      end
      mvne_pkg::ACT_TRI: begin
        e1x = longint'(pos_x[b]) - longint'(pos_x[a]);
        e1y = longint'(pos_y[b]) - longint'(pos_y[a]);
        e1z = longint'(pos_z[b]) - longint'(pos_z[a]);
        e2x = longint'(pos_x[c]) - longint'(pos_x[a]);
        e2y = longint'(pos_y[c]) - longint'(pos_y[a]);
        e2z = longint'(pos_z[c]) - longint'(pos_z[a]);
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        corner[0] = a; corner[1] = b; corner[2] = c;
        foreach (corner[i]) begin
          sum_x[corner[i]] = sat_sum(sum_x[corner[i]], cx);
          sum_y[corner[i]] = sat_sum(sum_y[corner[i]], cy);
          sum_z[corner[i]] = sat_sum(sum_z[corner[i]], cz);
        end
        return 1'b0;
      end
      mvne_pkg::ACT_READ: begin
        n = unit_normal(a, sum_x[a], sum_y[a], sum_z[a]);
        sum_x[a] = 0;
        sum_y[a] = 0;
        sum_z[a] = 0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic dir_row_t mk_row(logic [AW-1:0] act, int a, int b, int c,
                                      int px, int py, int pz, bit typed = 0,
                                      int ex = 0, int ey = 0, int ez = 0);
    dir_row_t r;
    r.act = act; r.a = VW'(a); r.b = VW'(b); r.c = VW'(c);
    r.px = CW'(px); r.py = CW'(py); r.pz = CW'(pz);
    r.typed = typed; r.ex = NW'(ex); r.ey = NW'(ey); r.ez = NW'(ez);
    return r;
  endfunction

  function automatic void add_row(dir_row_t r);
    rows[n_rows] = r;
    n_rows++;
  endfunction

  task automatic send_cmd(logic [AW-1:0] act, logic [VW-1:0] a, logic [VW-1:0] b,
                          logic [VW-1:0] c, logic [CW-1:0] px,
                          logic [CW-1:0] py, logic [CW-1:0] pz, bit typed,
                          normal_t typed_n);
    normal_t n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, pz, py, px, c, b, a};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (model_step(act, a, b, c, px, py, pz, n)) begin
      pend_normals[pend_wr % PEND_DEPTH] = typed ? typed_n : n;
      pend_wr++;
    end
  endtask

  function automatic logic [VW-1:0] pick_vertex();
    case ($urandom_range(0, 9))
      0:       return VW'($urandom_range(0, NV - 1));
      1:       return VW'(NV - 1 - int'($urandom_range(0, 3)));
      default: return VW'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return CW'(int'($urandom_range(0, 2047)) - 1024);
      default: return CW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_written();
    return written_list[$urandom_range(0, written_cnt - 1)];
  endfunction

  // Check each result transaction against the oldest pending normal.
  always @(posedge clk) begin
    normal_t got, want;
    if (rst_n && m_tvalid && m_tready) begin
      got = {m_tdata[11:0], m_tdata[27:12], m_tdata[43:28], m_tdata[59:44]};
      if (pend_wr == pend_rd) begin
        errors++;
        if (errors <= 10) $display("unexpected normal: vertex %0d", got.vert);
      end else begin
        want = pend_normals[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("normal mismatch: expected v=%0d (%0d,%0d,%0d) got v=%0d (%0d,%0d,%0d)",
                     want.vert, $signed(want.nx), $signed(want.ny), $signed(want.nz),
                     got.vert, $signed(got.nx), $signed(got.ny), $signed(got.nz));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    int act_sel, count;
    logic [VW-1:0] ca, cb, cc;
    normal_t tn;
    for (int i = 0; i < NV; i++) begin
      sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
      pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
      written[i] = 1'b0;
    end

    add_row(mk_row(mvne_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0, 16384, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 4095, 4095, 4095, 65535, 65535, 65535, 1, 0, 16384, 0));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 1, 0, 0, 256, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 2, 0, 0, 0, 0, 256));
    add_row(mk_row(mvne_pkg::ACT_TRI, 0, 1, 2, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0, -16384, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0, 16384, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 1, 0, 0, 0, 0, 0, 1, 0, -16384, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 2, 0, 0, 0, 0, 0, 1, 0, -16384, 0));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 4095, 0, 0, 16'h8000, 16'h8000, 16'h8000));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 4094, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 4093, 0, 0, 16'h7fff, 16'h8000, 16'h7fff));
    add_row(mk_row(mvne_pkg::ACT_WRITE, 4092, 0, 0, 16'h8000, 16'h7fff, 16'h7fff));
    for (int i = 0; i < 20; i++) add_row(mk_row(mvne_pkg::ACT_TRI, 4095, 4094, 4093, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_TRI, 4094, 4094, 4093, 0, 0, 0));
    add_row(mk_row(ACT_IGNORED, 4095, 4095, 4095, 65535, 65535, 65535));
    add_row(mk_row(mvne_pkg::ACT_READ, 4095, 0, 0, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 4094, 0, 0, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 4092, 0, 0, 0, 0, 0, 1, 0, 16384, 0));
    add_row(mk_row(mvne_pkg::ACT_TRI, 4092, 4093, 4094, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 4093, 0, 0, 0, 0, 0));
    add_row(mk_row(mvne_pkg::ACT_READ, 4092, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < n_rows; i++) begin
      tn.vert = rows[i].a; tn.nx = rows[i].ex; tn.ny = rows[i].ey; tn.nz = rows[i].ez;
      send_cmd(rows[i].act, rows[i].a, rows[i].b, rows[i].c, rows[i].px, rows[i].py,
               rows[i].pz, rows[i].typed, tn);
    end

    count = 0;
    while (count < RANDOM_ITEMS) begin
      if (count > RANDOM_ITEMS * 4 / 5) idle_on = 1'b0;
      act_sel = $urandom_range(0, 99);
      ca = pick_vertex();
      cb = pick_vertex();
      cc = pick_vertex();
      if (act_sel < 30) begin
        send_cmd(mvne_pkg::ACT_WRITE, ca, VW'($urandom_range(0, 4095)),
                 VW'($urandom_range(0, 4095)), pick_coord(), pick_coord(), pick_coord(),
                 0, tn);
        count++;
      end else if (act_sel < 70) begin
        ca = pick_written();
        cb = pick_written();
        cc = pick_written();
        if ($urandom_range(0, 15) == 0) cb = ca;
        send_cmd(mvne_pkg::ACT_TRI, ca, cb, cc, pick_coord(), pick_coord(), pick_coord(),
                 0, tn);
        count++;
      end else if (act_sel < 95) begin
        send_cmd(mvne_pkg::ACT_READ, ca, cb, cc, pick_coord(), pick_coord(), pick_coord(),
                 0, tn);
        count++;
      end else begin
        send_cmd(ACT_IGNORED, ca, cb, cc, pick_coord(), pick_coord(), pick_coord(), 0, tn);
      end
    end
    s_tvalid <= 1'b0;

    while (pend_wr != pend_rd) @(posedge clk);
    repeat (200) @(posedge clk);

    if (errors == 0 && pend_wr == pend_rd) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
